// ----- rtl/core/olmtf_pkg.sv -----
// package for the ordered list with move-to-front
// request/result structs, kind and status codes, cell command struct; no dependencies
package olmtf_pkg;

	// default list depth
	localparam int DEPTH_DEF = 32;
	// index/count width inside cell commands, covers depths up to 127
	localparam int IDX_W = 7;

	// request kinds
	localparam logic [2:0] KIND_APPEND  = 3'd0;
	localparam logic [2:0] KIND_DELETE  = 3'd1;
	localparam logic [2:0] KIND_MOVE    = 3'd2;
	localparam logic [2:0] KIND_REVERSE = 3'd3;
	localparam logic [2:0] KIND_PRINT   = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  position;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] entry;
		logic        entry_valid;
		logic [5:0]  count;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	// operations broadcast to the row of cells
	typedef enum logic [2:0] {
		CMD_HOLD   = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_SWAP   = 3'd3,
		CMD_REV    = 3'd4,
		CMD_ROT    = 3'd5
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] idx;   // delete start, or upper cell of a swap pair
		logic [IDX_W-1:0] cnt;   // current entry count
		logic             par;   // pair parity for a reverse round
		logic [31:0]      value; // word to append
	} cmd_t;

endpackage

// ----- rtl/core/olmtf_cell.sv -----
// one storage cell of the list row
// decides its own move from the broadcast command; depends on olmtf_pkg
module olmtf_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  olmtf_pkg::cmd_t    cmd,
	input  logic [31:0]        left,
	input  logic [31:0]        right,
	input  logic [31:0]        head,
	output logic [31:0]        word
);

	localparam logic [olmtf_pkg::IDX_W-1:0] ME  = olmtf_pkg::IDX_W'(IDX);
	localparam logic [olmtf_pkg::IDX_W-1:0] ME1 = olmtf_pkg::IDX_W'(IDX + 1);
	localparam logic                        PAR = ((IDX % 2) == 1);

	logic [31:0] word_q;
	logic [31:0] word_d;

	// next word from the command and this cell's place in the row
	always_comb begin
		word_d = word_q;
		case (cmd.op)
			olmtf_pkg::CMD_APPEND: begin
				if (ME == cmd.cnt) word_d = cmd.value;
			end
			olmtf_pkg::CMD_DELETE: begin
				if (ME >= cmd.idx && ME1 < cmd.cnt) word_d = right;
			end
			olmtf_pkg::CMD_SWAP: begin
				if (ME == cmd.idx) word_d = left;
				else if (ME1 == cmd.idx) word_d = right;
			end
			olmtf_pkg::CMD_REV: begin
				if (PAR == cmd.par && ME1 < cmd.cnt) word_d = right;
				else if (IDX != 0 && PAR != cmd.par && ME < cmd.cnt) word_d = left;
			end
			olmtf_pkg::CMD_ROT: begin
				if (ME1 == cmd.cnt) word_d = head;
				else if (ME1 < cmd.cnt) word_d = right;
			end
			default: word_d = word_q;
		endcase
	end

	// payload storage
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// ----- rtl/core/olmtf_ctrl.sv -----
// sequencer for the list: takes requests, drives cell commands, builds results
// depends on olmtf_pkg
module olmtf_ctrl #(
	parameter int DEPTH = olmtf_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  olmtf_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output olmtf_pkg::rsp_t  rsp,
	input  logic [31:0]      head,
	output olmtf_pkg::cmd_t  cmd
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOVE  = 5'b00010,
		ST_REV   = 5'b00100,
		ST_PRINT = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       step_q, step_d;
	logic [CW-1:0]       n_q, n_d;
	logic                par_q, par_d;
	olmtf_pkg::status_t  status_q, status_d;
	olmtf_pkg::rsp_t     rsp_q, rsp_d;
	logic                rsp_valid_q;
	logic                load;
	logic                out_free;
	logic                accept;
	logic                full;
	logic                pos_bad;
	logic [CW-1:0]       n_req;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign full      = (count_q == CW'(DEPTH));
	assign pos_bad   = (req.position == 8'd0) || (req.position > 8'(count_q));
	assign n_req     = (req.position < 8'(count_q)) ? CW'(req.position) : count_q;

	// request decode and sequencing
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		step_d    = step_q;
		n_d       = n_q;
		par_d     = par_q;
		status_d  = status_q;
		load      = 1'b0;
		rsp_d     = rsp_q;
		cmd.op    = olmtf_pkg::CMD_HOLD;
		cmd.idx   = '0;
		cmd.cnt   = olmtf_pkg::IDX_W'(count_q);
		cmd.par   = par_q;
		cmd.value = req.value;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_d = olmtf_pkg::STATUS_OK;
					state_d  = ST_RESP;
					case (req.kind)
						olmtf_pkg::KIND_APPEND: begin
							if (full) begin
								status_d = olmtf_pkg::STATUS_FULL;
							end else begin
								cmd.op  = olmtf_pkg::CMD_APPEND;
								count_d = count_q + 1'b1;
							end
						end
						olmtf_pkg::KIND_DELETE: begin
							if (pos_bad) begin
								status_d = olmtf_pkg::STATUS_RANGE;
							end else begin
								cmd.op  = olmtf_pkg::CMD_DELETE;
								cmd.idx = olmtf_pkg::IDX_W'(req.position - 8'd1);
								count_d = count_q - 1'b1;
							end
						end
						olmtf_pkg::KIND_MOVE: begin
							if (pos_bad) begin
								status_d = olmtf_pkg::STATUS_RANGE;
							end else if (req.position != 8'd1) begin
								step_d  = CW'(req.position - 8'd1);
								state_d = ST_MOVE;
							end
						end
						olmtf_pkg::KIND_REVERSE: begin
							if (count_q > CW'(1)) begin
								step_d  = count_q;
								par_d   = 1'b0;
								state_d = ST_REV;
							end
						end
						olmtf_pkg::KIND_PRINT: begin
							if (n_req != '0) begin
								step_d  = '0;
								n_d     = n_req;
								state_d = ST_PRINT;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			// bubble the chosen entry toward the head, one neighbor swap a cycle
			ST_MOVE: begin
				cmd.op  = olmtf_pkg::CMD_SWAP;
				cmd.idx = olmtf_pkg::IDX_W'(step_q);
				step_d  = step_q - 1'b1;
				if (step_q == CW'(1)) state_d = ST_RESP;
			end
			// odd-even rounds of pair swaps, count rounds reverse the list
			ST_REV: begin
				cmd.op = olmtf_pkg::CMD_REV;
				step_d = step_q - 1'b1;
				par_d  = !par_q;
				if (step_q == CW'(1)) state_d = ST_RESP;
			end
			// rotate the whole list past the head, emitting the first n words
			ST_PRINT: begin
				if (step_q >= n_q || out_free) begin
					cmd.op = olmtf_pkg::CMD_ROT;
					step_d = step_q + 1'b1;
					if (step_q < n_q) begin
						load              = 1'b1;
						rsp_d.entry       = head;
						rsp_d.entry_valid = 1'b1;
						rsp_d.count       = 6'(count_q);
						rsp_d.status      = olmtf_pkg::STATUS_OK;
						rsp_d.last        = (step_q == n_q - 1'b1);
					end
					if (step_q == count_q - 1'b1) state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					load              = 1'b1;
					rsp_d.entry       = '0;
					rsp_d.entry_valid = 1'b0;
					rsp_d.count       = 6'(count_q);
					rsp_d.status      = status_q;
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// sequencing registers and result payload
	always_ff @(posedge clk) begin
		step_q   <= step_d;
		n_q      <= n_d;
		par_q    <= par_d;
		status_q <= status_d;
		rsp_q    <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/ordered_list_move_to_front.sv -----
// top level of the ordered list with move-to-front
// a sequencer and a row of DEPTH cells; depends on olmtf_pkg, olmtf_ctrl, olmtf_cell
//
//   port group  flow  payload  handshake
//   request     in    req      req_valid / req_stall
//   result      out   rsp      rsp_valid / rsp_stall
//
// one request at a time, req_stall holding off the next until the sequencer idles;
// append, delete, move of position 1, reverse of a short list, ignored
// kinds, print of nothing and bad positions go straight to the result
// move to front of position p > 1 first does p - 1 neighbor swaps
// reverse first does count odd-even swap rounds
// print rotates the row once around, one entry for each of the first n
// rotations; every request waits while rsp_stall holds the result register
// reset empties the list; stored words are not cleared
module ordered_list_move_to_front #(
	parameter int DEPTH = olmtf_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  olmtf_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output olmtf_pkg::rsp_t  rsp
);

	olmtf_pkg::cmd_t cmd;
	logic [31:0]     words [DEPTH];

	olmtf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.head      (words[0]),
		.cmd       (cmd)
	);

	// row of cells, each linked to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = words[i+1];
		end
		olmtf_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.head  (words[0]),
			.word  (words[i])
		);
	end

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for ordered_list_move_to_front
// keeps its own copy of the list and checks every result transfer in order;
// depends on olmtf_pkg and the ordered_list_move_to_front rtl
module tb;

	localparam int LIST_DEPTH = olmtf_pkg::DEPTH_DEF;
	localparam int RUN_ITEMS = 310;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PRINT_CAP = 100;
	// kinds the block ignores
	localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

	// idling phases of the run
	typedef enum logic [1:0] {
		PH_STEADY     = 2'd0,
		PH_SRC_IDLE   = 2'd1,
		PH_SINK_STALL = 2'd2,
		PH_BOTH       = 2'd3
	} phase_t;

	typedef struct packed {
		olmtf_pkg::req_t req;
		phase_t          phase;
		logic            drain;  // wait for every outstanding result before sending
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	olmtf_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	olmtf_pkg::rsp_t rsp;

	stim_t request_q[$];
	olmtf_pkg::rsp_t list_results_q[$];

	// shadow of the list contents
	logic [31:0] list_words [0:LIST_DEPTH-1];
	int list_count = 0;

	// generator side bookkeeping
	int gen_count = 0;
	int gen_items = 0;
	phase_t gen_phase = PH_STEADY;
	logic gen_drain = 1'b0;

	phase_t cur_phase = PH_STEADY;
	logic req_took = 1'b0;
	int cycles = 0;
	int mismatch_count = 0;
	int rsp_seen = 0;

	ordered_list_move_to_front dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// apply one request to the shadow list and queue the results it causes
	function automatic void apply_list_op(input olmtf_pkg::req_t r);
		olmtf_pkg::rsp_t res;
		logic [31:0] w;
		logic [31:0] t;
		int n;
		int i;
		res = '0;
		res.status = olmtf_pkg::STATUS_OK;
		res.last = 1'b1;
		n = 0;
		case (r.kind)
		olmtf_pkg::KIND_APPEND: begin
			if (list_count >= LIST_DEPTH) begin
				res.status = olmtf_pkg::STATUS_FULL;
			end else begin
				list_words[list_count] = r.value;
				list_count++;
			end
		end
		olmtf_pkg::KIND_DELETE, olmtf_pkg::KIND_MOVE: begin
			if (r.position == 0 || r.position > list_count) begin
				res.status = olmtf_pkg::STATUS_RANGE;
			end else begin
				w = list_words[r.position - 1];
				for (i = r.position - 1; i < list_count - 1; i++)
					list_words[i] = list_words[i + 1];
				list_count--;
				if (r.kind == olmtf_pkg::KIND_MOVE) begin
					for (i = list_count; i > 0; i--)
						list_words[i] = list_words[i - 1];
					list_words[0] = w;
					list_count++;
				end
			end
		end
		olmtf_pkg::KIND_REVERSE: begin
			for (i = 0; i < list_count / 2; i++) begin
				t = list_words[i];
				list_words[i] = list_words[list_count - 1 - i];
				list_words[list_count - 1 - i] = t;
			end
		end
		olmtf_pkg::KIND_PRINT: begin
			n = (r.position < list_count) ? r.position : list_count;
		end
		default: ;
		endcase
		res.count = list_count[5:0];
		if (n > 0) begin
			// one entry per printed slot, last on the final one
			for (i = 0; i < n; i++) begin
				res.entry = list_words[i];
				res.entry_valid = 1'b1;
				res.last = (i == n - 1);
				list_results_q.push_back(res);
			end
		end else begin
			list_results_q.push_back(res);
		end
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch on result %0d, %0s: got %h, want %h", rsp_seen, what, got,
				want);
		mismatch_count++;
	endtask

	// percent of cycles a side holds off in a phase
	function automatic int hold_pct(input phase_t p, input logic sink);
		case (p)
		PH_SRC_IDLE:   return sink ? 0 : 82;
		PH_SINK_STALL: return sink ? 82 : 0;
		PH_BOTH:       return 12;
		default:       return 0;
		endcase
	endfunction

	// queue one request and track the entry count it leaves behind
	task automatic queue_req(input logic [2:0] kind, input int pos, input logic [31:0] value);
		stim_t s;
		s.req.kind = kind;
		s.req.position = pos[7:0];
		s.req.value = value;
		s.phase = gen_phase;
		s.drain = gen_drain;
		request_q.push_back(s);
		gen_drain = 1'b0;
		gen_items++;
		if (kind == olmtf_pkg::KIND_APPEND && gen_count < LIST_DEPTH)
			gen_count++;
		if (kind == olmtf_pkg::KIND_DELETE && pos >= 1 && pos <= gen_count)
			gen_count--;
	endtask

	// a request that fits the current list
	task automatic queue_sane_req();
		int r;
		int pos;
		logic [31:0] value;
		r = $urandom_range(99);
		pos = (gen_count > 0) ? $urandom_range(gen_count, 1) : 0;
		if ($urandom_range(9) == 0)
			pos = gen_count;
		value = $urandom;
		if ($urandom_range(15) == 0)
			value = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
		if (r < 30)
			queue_req(olmtf_pkg::KIND_APPEND, 0, value);
		else if (r < 45)
			queue_req(olmtf_pkg::KIND_DELETE, pos, $urandom);
		else if (r < 65)
			queue_req(olmtf_pkg::KIND_MOVE, pos, $urandom);
		else if (r < 75)
			queue_req(olmtf_pkg::KIND_REVERSE, $urandom_range(255), $urandom);
		else
			queue_req(olmtf_pkg::KIND_PRINT, $urandom_range(gen_count + 2, 0), $urandom);
	endtask

	// stimulus and end of run
	initial begin : stimulus
		int r;
		int extra;
		// empty list corners
		queue_req(olmtf_pkg::KIND_PRINT, 5, 32'h0);
		queue_req(olmtf_pkg::KIND_REVERSE, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 1, 32'h0);
		queue_req(olmtf_pkg::KIND_MOVE, 1, 32'h0);
		queue_req(olmtf_pkg::KIND_APPEND, 0, 32'h0000_0000);
		queue_req(olmtf_pkg::KIND_APPEND, 0, 32'hFFFF_FFFF);
		queue_req(olmtf_pkg::KIND_APPEND, 0, 32'hA5A5_A5A5);
		queue_req(olmtf_pkg::KIND_APPEND, 0, 32'h5A5A_5A5A);
		// print nothing, then more than the count
		queue_req(olmtf_pkg::KIND_PRINT, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_PRINT, 255, 32'h0);
		// move the tail, then the head, then bad positions
		queue_req(olmtf_pkg::KIND_MOVE, 4, 32'h0);
		queue_req(olmtf_pkg::KIND_MOVE, 1, 32'h0);
		queue_req(olmtf_pkg::KIND_MOVE, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 255, 32'hFFFF_FFFF);
		queue_req(olmtf_pkg::KIND_REVERSE, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_PRINT, 2, 32'h0);
		// ignored kinds
		queue_req(KIND_SPARE_LO, 255, $urandom);
		queue_req(KIND_SPARE_MID, 128, $urandom);
		queue_req(KIND_SPARE_HI, 0, $urandom);
		queue_req(olmtf_pkg::KIND_DELETE, 4, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 1, 32'h0);
		queue_req(olmtf_pkg::KIND_REVERSE, 0, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 1, 32'h0);
		queue_req(olmtf_pkg::KIND_DELETE, 1, 32'h0);

		// random part, phases rotate every 40 requests
		gen_drain = 1'b1;
		while (gen_items < RUN_ITEMS) begin
			gen_phase = phase_t'((gen_items / 40) % 4);
			if ($urandom_range(99) < 3)
				gen_drain = 1'b1;
			r = $urandom_range(99);
			if (r < 10) begin
				// fill to the top and push past it
				while (gen_count < LIST_DEPTH)
					queue_req(olmtf_pkg::KIND_APPEND, $urandom_range(255), $urandom);
				extra = $urandom_range(2, 1);
				repeat (extra) queue_req(olmtf_pkg::KIND_APPEND, 0, $urandom);
			end else if (r < 18) begin
				// empty the list from random positions
				while (gen_count > 0)
					queue_req(olmtf_pkg::KIND_DELETE, $urandom_range(gen_count, 1), $urandom);
			end else if (r < 88) begin
				queue_sane_req();
			end else begin
				queue_req(3'($urandom_range(7)), $urandom_range(255), $urandom);
			end
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || req_valid || list_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// request driver and result stall, both at the falling edge
	always @(negedge clk) begin : drive_req
		stim_t nxt;
		logic send;
		send = 1'b0;
		if (arst_n) begin
			if (!req_valid || req_took) begin
				if (request_q.size() != 0) begin
					nxt = request_q[0];
					cur_phase = nxt.phase;
					if (nxt.drain && list_results_q.size() != 0)
						send = 1'b0;
					else
						send = ($urandom_range(99) >= hold_pct(cur_phase, 1'b0));
				end
				if (send) begin
					void'(request_q.pop_front());
					req <= nxt.req;
				end
				req_valid <= send;
			end
			rsp_stall <= ($urandom_range(99) < hold_pct(cur_phase, 1'b1));
		end
	end

	// transfer monitor and run limit
	always @(posedge clk) begin : watch_rsp
		olmtf_pkg::rsp_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			req_took = arst_n && req_valid && !req_stall;
			if (req_took)
				apply_list_op(req);
			// compare a result transfer with the oldest expectation
			if (arst_n && rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (list_results_q.size() == 0) begin
					log_mismatch("unexpected result entry", rsp.entry, 32'h0);
				end else begin
					want = list_results_q.pop_front();
					if (rsp.entry !== want.entry)
						log_mismatch("entry", rsp.entry, want.entry);
					if (rsp.entry_valid !== want.entry_valid)
						log_mismatch("entry_valid", rsp.entry_valid, want.entry_valid);
					if (rsp.count !== want.count)
						log_mismatch("count", rsp.count, want.count);
					if (rsp.status !== want.status)
						log_mismatch("status", rsp.status, want.status);
					if (rsp.last !== want.last)
						log_mismatch("last", rsp.last, want.last);
				end
			end
		end
	end

endmodule

// ----- sim.f -----
rtl/core/olmtf_pkg.sv
rtl/core/olmtf_cell.sv
rtl/core/olmtf_ctrl.sv
rtl/core/ordered_list_move_to_front.sv
tb/tb.sv
